// File: hdl/dsat_pkg.sv
// Shared types, widths and register map of the disk sector address translator.
package dsat_pkg;

	localparam int SECTOR_BITS_DEF = 32;

	localparam int KIND_W = 2;
	localparam int SEC_W  = 32;
	localparam int CNT_W  = 7;
	localparam int SPT_W  = 6;
	localparam int HPC_W  = 9;
	localparam int DRV_W  = 8;
	localparam int WORD_W = 16;
	localparam int CYL_W  = 10;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [HPC_W-1:0] HPC_RST = 9'd16;
	localparam logic [SPT_W-1:0] SPT_RST = 6'd63;
	localparam logic [DRV_W-1:0] DRV_RST = 8'd128;

	typedef enum logic [2:0] {
		REG_USE_LBA = 3'd0,
		REG_START   = 3'd1,
		REG_HEADS   = 3'd2,
		REG_SPT     = 3'd3,
		REG_DRIVE   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEC_W-1:0]  relative_sector;
		logic [CNT_W-1:0]  sector_count;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind_out;
		logic              uses_lba;
		logic [SEC_W-1:0]  absolute_sector;
		logic [WORD_W-1:0] sector_cylinder_word;
		logic [WORD_W-1:0] drive_head_word;
		logic [CNT_W-1:0]  count_out;
		logic              cylinder_overflow;
	} rsp_t;

	// fields that ride along the first divider row
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  count;
		logic              lba;
		logic [SEC_W-1:0]  abs_sec;
	} side1_t;

	// second divider row also carries the sector remainder
	typedef struct packed {
		side1_t            base;
		logic [SPT_W-1:0]  sec;
	} side2_t;

endpackage

// File: hdl/dsat_div_cell.sv
// One restoring-division cell: resolves one quotient bit and registers it.
module dsat_div_cell #(
	parameter int DW = 32,
	parameter int RW = 6,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [RW-1:0] div,
	input  logic [RW-1:0] rem_i,
	input  logic [DW-1:0] quo_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [RW-1:0] rem_o,
	output logic [DW-1:0] quo_o,
	output logic [SW-1:0] side_o
);

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          fits;
	logic [RW-1:0] rem_d;

	logic          valid_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] side_q;

	// shift next dividend bit into the partial remainder
	assign trial = {rem_i, quo_i[DW-1]};
	assign diff  = trial - {1'b0, div};
	assign fits  = trial >= {1'b0, div};
	assign rem_d = fits ? diff[RW-1:0] : trial[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			quo_q  <= {quo_i[DW-2:0], fits};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign quo_o   = quo_q;
	assign side_o  = side_q;

endmodule

// File: hdl/dsat_div_chain.sv
// Row of division cells, one quotient bit per cell, dividend MSB first.
module dsat_div_chain #(
	parameter int DW = 32,
	parameter int RW = 6,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [DW-1:0] dividend,
	input  logic [RW-1:0] div,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [DW-1:0] quotient,
	output logic [RW-1:0] remainder,
	output logic [SW-1:0] side_o
);

	logic          v_tap [DW+1];
	logic [RW-1:0] r_tap [DW+1];
	logic [DW-1:0] q_tap [DW+1];
	logic [SW-1:0] s_tap [DW+1];

	assign v_tap[0] = valid_i;
	assign r_tap[0] = '0;
	assign q_tap[0] = dividend;
	assign s_tap[0] = side_i;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		dsat_div_cell #(
			.DW(DW),
			.RW(RW),
			.SW(SW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(v_tap[i]),
			.div    (div),
			.rem_i  (r_tap[i]),
			.quo_i  (q_tap[i]),
			.side_i (s_tap[i]),
			.valid_o(v_tap[i+1]),
			.rem_o  (r_tap[i+1]),
			.quo_o  (q_tap[i+1]),
			.side_o (s_tap[i+1])
		);
	end

	assign valid_o   = v_tap[DW];
	assign quotient  = q_tap[DW];
	assign remainder = r_tap[DW];
	assign side_o    = s_tap[DW];

endmodule

// File: hdl/disk_sector_address_translator.sv
// Throughput: one item per cycle while the output buffer is not full; two rows of
// SECTOR_BITS division cells, one quotient bit per cell (sectors per track, then
// heads), all in flight at once. A two-entry output buffer holds results; the
// input stage and both rows stall while it is full.
// Reset: asynchronous on arst_n; clears valid bits and configuration registers
// (CHS mode, start 0, 16 heads, 63 sectors per track, drive 128).
module disk_sector_address_translator
	import dsat_pkg::*;
#(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	localparam int SW1 = $bits(side1_t);
	localparam int SW2 = $bits(side2_t);

	logic              use_lba_q;
	logic [SEC_W-1:0]  start_q;
	logic [HPC_W-1:0]  hpc_q;
	logic [SPT_W-1:0]  spt_q;
	logic [DRV_W-1:0]  drive_q;
	reg_idx_t          reg_idx;

	logic [SPT_W-1:0]  spt_eff;
	logic [HPC_W-1:0]  hpc_eff;

	logic                   adv;
	logic [SEC_W:0]         sum;
	logic                   valid_s0;
	logic [SECTOR_BITS-1:0] abs_s0;
	side1_t                 side_s0;

	logic                   v1;
	logic [SECTOR_BITS-1:0] track;
	logic [SPT_W-1:0]       sec_rem;
	logic [SW1-1:0]         side1_vec;
	side2_t                 side2_in;

	logic                   v2;
	logic [SECTOR_BITS-1:0] cyl;
	logic [HPC_W-1:0]       head;
	logic [SW2-1:0]         side2_vec;
	side2_t                 side2_out;

	rsp_t res;
	rsp_t rsp_q;
	rsp_t skid_q;
	logic rsp_valid_q;
	logic skid_valid_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_lba_q <= 1'b0;
			start_q   <= '0;
			hpc_q     <= HPC_RST;
			spt_q     <= SPT_RST;
			drive_q   <= DRV_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_USE_LBA: use_lba_q <= pwdata[0];
				REG_START:   start_q   <= pwdata[SEC_W-1:0];
				REG_HEADS:   hpc_q     <= pwdata[HPC_W-1:0];
				REG_SPT:     spt_q     <= pwdata[SPT_W-1:0];
				REG_DRIVE:   drive_q   <= pwdata[DRV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_USE_LBA: prdata = DATA_W'(use_lba_q);
			REG_START:   prdata = DATA_W'(start_q);
			REG_HEADS:   prdata = DATA_W'(hpc_q);
			REG_SPT:     prdata = DATA_W'(spt_q);
			REG_DRIVE:   prdata = DATA_W'(drive_q);
			default:     prdata = '0;
		endcase
	end

	// zero geometry counts behave as one
	assign spt_eff = (spt_q == '0) ? SPT_W'(1) : spt_q;
	assign hpc_eff = (hpc_q == '0) ? HPC_W'(1) : hpc_q;

	// ---------------- input stage ----------------
	assign adv       = !skid_valid_q;
	assign req_ready = adv;
	assign sum       = {1'b0, req.relative_sector} + {1'b0, start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abs_s0          <= SECTOR_BITS'(sum);
			side_s0.kind    <= req.kind;
			side_s0.count   <= req.sector_count;
			side_s0.lba     <= use_lba_q;
			side_s0.abs_sec <= SEC_W'(SECTOR_BITS'(sum));
		end
	end

	// ---------------- sector / track split ----------------
	dsat_div_chain #(
		.DW(SECTOR_BITS),
		.RW(SPT_W),
		.SW(SW1)
	) u_spt_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_i  (valid_s0),
		.dividend (abs_s0),
		.div      (spt_eff),
		.side_i   (side_s0),
		.valid_o  (v1),
		.quotient (track),
		.remainder(sec_rem),
		.side_o   (side1_vec)
	);

	assign side2_in.base = side1_t'(side1_vec);
	assign side2_in.sec  = sec_rem;

	// ---------------- head / cylinder split ----------------
	dsat_div_chain #(
		.DW(SECTOR_BITS),
		.RW(HPC_W),
		.SW(SW2)
	) u_hpc_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_i  (v1),
		.dividend (track),
		.div      (hpc_eff),
		.side_i   (side2_in),
		.valid_o  (v2),
		.quotient (cyl),
		.remainder(head),
		.side_o   (side2_vec)
	);

	assign side2_out = side2_t'(side2_vec);

	// ---------------- result packing ----------------
	always_comb begin
		res.kind_out        = side2_out.base.kind;
		res.uses_lba        = side2_out.base.lba;
		res.absolute_sector = side2_out.base.abs_sec;
		res.count_out       = side2_out.base.count;
		if (side2_out.base.lba) begin
			res.sector_cylinder_word = '0;
			res.drive_head_word      = {8'h00, drive_q};
			res.cylinder_overflow    = 1'b0;
		end else begin
			res.sector_cylinder_word = {cyl[7:0], cyl[CYL_W-1:8],
				SPT_W'(side2_out.sec + SPT_W'(1))};
			res.drive_head_word      = {head[7:0], drive_q};
			res.cylinder_overflow    = |cyl[SECTOR_BITS-1:CYL_W];
		end
	end

	// ---------------- output register plus skid entry ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (rsp_valid_q && rsp_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= v2;
			end
		end else if (!rsp_valid_q) begin
			rsp_valid_q <= v2;
		end else if (v2 && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid_q && rsp_ready) begin
			rsp_q <= skid_valid_q ? skid_q : res;
		end else if (!rsp_valid_q) begin
			rsp_q <= res;
		end else if (v2 && !skid_valid_q) begin
			skid_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid entry held while output register empty");

	a_lba_words: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.uses_lba) |->
		(rsp.sector_cylinder_word == '0 && !rsp.cylinder_overflow &&
		 rsp.drive_head_word[15:8] == 8'h00))
		else $error("LBA result carries CHS fields");

	a_chs_sector_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.uses_lba) |-> (rsp.sector_cylinder_word[5:0] != '0))
		else $error("CHS sector number is zero");

	a_full_stalls_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !rsp_ready) |=> ($stable(valid_s0) && $stable(v2)))
		else $error("divider rows advanced while output buffer full");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the disk sector address translator: directed and random requests.
`timescale 1ns / 100ps

module tb
	import dsat_pkg::*;
();

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid;
	logic              req_ready;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp;

	// shadow copy of the translation settings
	logic              cfg_use_lba;
	logic [SEC_W-1:0]  cfg_start;
	logic [HPC_W-1:0]  cfg_heads;
	logic [SPT_W-1:0]  cfg_spt;
	logic [DRV_W-1:0]  cfg_drive;

	rsp_t expected_translations[$];
	int   mismatch_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_cycles = 0;
	int   hold_req_id = 0;
	int   hold_ack_id = 0;
	int   hold_left = 0;

	disk_sector_address_translator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAIL disk_sector_address_translator");
		$finish;
	end

	function automatic rsp_t predict_translation(input req_t r);
		rsp_t        p;
		logic [31:0] abs_sec;
		logic [31:0] spt_eff;
		logic [31:0] hpc_eff;
		logic [31:0] sec;
		logic [31:0] track;
		logic [31:0] head;
		logic [31:0] cyl;
		p = '0;
		abs_sec = r.relative_sector + cfg_start;
		p.kind_out = r.kind;
		p.uses_lba = cfg_use_lba;
		p.absolute_sector = abs_sec;
		p.count_out = r.sector_count;
		p.drive_head_word = {8'h00, cfg_drive};
		if (!cfg_use_lba) begin
			// zero geometry counts behave as one
			spt_eff = (cfg_spt == '0) ? 32'd1 : 32'(cfg_spt);
			hpc_eff = (cfg_heads == '0) ? 32'd1 : 32'(cfg_heads);
			sec = abs_sec % spt_eff + 32'd1;
			track = abs_sec / spt_eff;
			head = track % hpc_eff;
			cyl = track / hpc_eff;
			p.cylinder_overflow = (cyl > 32'd1023);
			p.drive_head_word = {head[7:0], cfg_drive};
			p.sector_cylinder_word = {cyl[7:0], cyl[9:8], sec[5:0]};
		end
		return p;
	endfunction

	function automatic req_t make_request(input logic [1:0] kind, input logic [31:0] rel,
			input logic [6:0] count);
		req_t r;
		r.kind = kind;
		r.relative_sector = rel;
		r.sector_count = count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%08h want 0x%08h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_translations.size() == 0) begin
				report_mismatch("unexpected item", rsp.absolute_sector, 32'd0);
			end else begin
				want = expected_translations.pop_front();
				if (rsp.kind_out !== want.kind_out)
					report_mismatch("kind_out", 32'(rsp.kind_out), 32'(want.kind_out));
				if (rsp.uses_lba !== want.uses_lba)
					report_mismatch("uses_lba", 32'(rsp.uses_lba), 32'(want.uses_lba));
				if (rsp.absolute_sector !== want.absolute_sector)
					report_mismatch("absolute_sector", rsp.absolute_sector,
						want.absolute_sector);
				if (rsp.sector_cylinder_word !== want.sector_cylinder_word)
					report_mismatch("sector_cylinder_word", 32'(rsp.sector_cylinder_word),
						32'(want.sector_cylinder_word));
				if (rsp.drive_head_word !== want.drive_head_word)
					report_mismatch("drive_head_word", 32'(rsp.drive_head_word),
						32'(want.drive_head_word));
				if (rsp.count_out !== want.count_out)
					report_mismatch("count_out", 32'(rsp.count_out), 32'(want.count_out));
				if (rsp.cylinder_overflow !== want.cylinder_overflow)
					report_mismatch("cylinder_overflow", 32'(rsp.cylinder_overflow),
						32'(want.cylinder_overflow));
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req_id != hold_ack_id) begin
			hold_left = hold_cycles;
			hold_ack_id = hold_req_id;
		end
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_USE_LBA: cfg_use_lba = value[0];
			REG_START:   cfg_start = value[SEC_W-1:0];
			REG_HEADS:   cfg_heads = value[HPC_W-1:0];
			REG_SPT:     cfg_spt = value[SPT_W-1:0];
			REG_DRIVE:   cfg_drive = value[DRV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_request(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_translations.push_back(predict_translation(r));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_translations.size() != 0) @(posedge clk);
	endtask

	// reset geometry: 63 sectors, 16 heads, 1008 sectors per cylinder
	task automatic test_chs_defaults();
		send_request(make_request(2'd0, 32'd0, 7'd0));
		send_request(make_request(2'd1, 32'd62, 7'd127));
		send_request(make_request(2'd2, 32'd63, 7'd1));
		send_request(make_request(2'd3, 32'd1007, 7'd64));
		send_request(make_request(2'd0, 32'd1008, 7'd8));
		send_request(make_request(2'd1, 32'd1032191, 7'd127));
		send_request(make_request(2'd2, 32'd1032192, 7'd0));
		send_request(make_request(2'd3, 32'hffff_ffff, 7'd127));
		send_request(make_request(2'd0, 32'h5555_aaaa, 7'h55));
		wait_drained();
	endtask

	task automatic test_lba_wrap();
		write_register(REG_USE_LBA, 32'd1);
		write_register(REG_START, 32'hffff_fff0);
		write_register(REG_DRIVE, 32'd0);
		send_request(make_request(2'd1, 32'h0000_000f, 7'd3));
		send_request(make_request(2'd2, 32'h0000_0010, 7'd127));
		send_request(make_request(2'd3, 32'hffff_ffff, 7'd0));
		send_request(make_request(2'd0, 32'd0, 7'h2a));
		wait_drained();
	endtask

	task automatic test_geometry_extremes();
		write_register(REG_USE_LBA, 32'd0);
		write_register(REG_START, 32'd0);
		write_register(REG_SPT, 32'd0);
		write_register(REG_HEADS, 32'd0);
		write_register(REG_DRIVE, 32'd255);
		send_request(make_request(2'd0, 32'd5, 7'd1));
		send_request(make_request(2'd1, 32'hffff_ffff, 7'd2));
		wait_drained();
		// head numbers above 255 lose bit 8 in the drive/head word
		write_register(REG_SPT, 32'd1);
		write_register(REG_HEADS, 32'd511);
		send_request(make_request(2'd2, 32'd510, 7'd3));
		send_request(make_request(2'd0, 32'd511, 7'd4));
		send_request(make_request(2'd1, 32'd256, 7'd5));
		wait_drained();
		write_register(REG_SPT, 32'd63);
		write_register(REG_HEADS, 32'd256);
		send_request(make_request(2'd2, 32'd16065, 7'd6));
		send_request(make_request(2'd3, 32'd16128, 7'd7));
		wait_drained();
	endtask

	task automatic apply_random_setting();
		logic [31:0] start_val;
		logic [31:0] heads_val;
		case ($urandom_range(3))
			0: start_val = 32'd0;
			1: start_val = 32'hffff_ffff;
			default: start_val = $urandom;
		endcase
		case ($urandom_range(7))
			0: heads_val = 32'd0;
			1: heads_val = 32'd1;
			2: heads_val = 32'd256;
			3: heads_val = 32'd511;
			default: heads_val = $urandom_range(1, 256);
		endcase
		write_register(REG_USE_LBA, ($urandom_range(3) == 0) ? 32'd1 : 32'd0);
		write_register(REG_START, start_val);
		write_register(REG_HEADS, heads_val);
		write_register(REG_SPT, ($urandom_range(3) == 0) ? 32'd63 : $urandom_range(0, 63));
		write_register(REG_DRIVE, $urandom_range(0, 255));
	endtask

	function automatic req_t random_request();
		logic [31:0] rel;
		case ($urandom_range(3))
			0: rel = $urandom;
			1: rel = $urandom_range(0, 2000000);
			2: rel = 32'd0 - cfg_start - $urandom_range(0, 100);
			default: rel = $urandom_range(0, 4095);
		endcase
		return make_request(2'($urandom_range(0, 3)), rel, 7'($urandom_range(0, 127)));
	endfunction

	task automatic test_random_traffic();
		int idle_pct[4] = '{0, 60, 0, 10};
		int stall_pct[4] = '{0, 0, 60, 10};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int s = 0; s < 5; s++) begin
				apply_random_setting();
				for (int n = 0; n < 90; n++)
					send_request(random_request());
				wait_drained();
			end
		end
	endtask

	// hold results off long enough that the pipeline fills and the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_random_setting();
		hold_cycles = 400;
		hold_req_id++;
		for (int n = 0; n < 150; n++)
			send_request(random_request());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		cfg_use_lba = 1'b0;
		cfg_start = '0;
		cfg_heads = HPC_RST;
		cfg_spt = SPT_RST;
		cfg_drive = DRV_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_chs_defaults();
		test_lba_wrap();
		test_geometry_extremes();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS disk_sector_address_translator");
		else
			$display("FAIL disk_sector_address_translator");
		$finish;
	end

endmodule
